// File: hw/rtl/swqt_pkg.sv
// Package for the semaphore wait-queue table: sizes, request codes, FSM states.
// No dependencies.
package swqt_pkg;
  localparam int NumSem   = 16;
  localparam int NumProcs = 32;
  localparam int KeyBits  = 32;
  localparam int SemW     = $clog2(NumSem);
  localparam int PidW     = $clog2(NumProcs);

  typedef enum logic [1:0] {
    REQ_P   = 2'd0,
    REQ_V   = 2'd1,
    REQ_REM = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_DECIDE,
    ST_WON,
    ST_POP,
    ST_RD_WON,
    ST_GOT_WON,
    ST_REM_HEAD,
    ST_WALK,
    ST_WALK_RD,
    ST_OUT
  } state_e;
endpackage

// File: hw/rtl/swqt_link_ram.sv
// Process memory: next-waiter link and owning descriptor of each process,
// one write port with a field enable each, one registered read port.
// Depends on swqt_pkg.
module swqt_link_ram (
  input  logic                      clk_i,
  input  logic                      we_next_i,
  input  logic                      we_won_i,
  input  logic [swqt_pkg::PidW-1:0] waddr_i,
  input  logic [swqt_pkg::PidW-1:0] wnext_i,
  input  logic [swqt_pkg::SemW-1:0] wwon_i,
  input  logic [swqt_pkg::PidW-1:0] raddr_i,
  output logic [swqt_pkg::PidW-1:0] rnext_o,
  output logic [swqt_pkg::SemW-1:0] rwon_o
);
  localparam int PW = swqt_pkg::PidW;
  localparam int SW = swqt_pkg::SemW;

  logic [SW+PW-1:0] mem [swqt_pkg::NumProcs];

  always_ff @(posedge clk_i) begin
    if (we_next_i) begin
      mem[waddr_i][PW-1:0] <= wnext_i;
    end
    if (we_won_i) begin
      mem[waddr_i][PW+:SW] <= wwon_i;
    end
    {rwon_o, rnext_o} <= mem[raddr_i];
  end
endmodule

// File: hw/rtl/semaphore_wait_queue_table.sv
// Top level of the semaphore wait-queue table engine.
// Depends on swqt_pkg and swqt_link_ram.
//
// channel  dir  tdata fields (low first)                          tuser
// s_axis   in   sem_key[31:0] sem_value[47:32] proc_id[52:48]     req_type
// m_axis   out  new_value[15:0] caller_blocked[16] woken_valid[17]
//               woken_proc[22:18] table_full[23]
//               empty_queue_warning[24] removed[25]               -
//
// One request at a time. P and V scan the 16 descriptors, one memory read a
// cycle, then decide and update. Remove reads the process entry and its queue
// head, then walks the links, one link read per hop, up to 32 hops. The unused
// code answers in the cycle after its beat. The next input beat is taken the
// cycle after the result beat. Reset clears the used and waiting bits.
module semaphore_wait_queue_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // sem_key, sem_value, proc_id
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // new_value, caller_blocked, woken_valid,
                                      // woken_proc, table_full,
                                      // empty_queue_warning, removed
);
  localparam int SW = swqt_pkg::SemW;
  localparam int PW = swqt_pkg::PidW;
  localparam int KB = swqt_pkg::KeyBits;
  localparam int DW = KB + 2 * PW;

  swqt_pkg::state_e state_q, state_d;

  // descriptor entry: key, queue head, queue tail
  logic [DW-1:0] desc_mem [swqt_pkg::NumSem];
  logic [DW-1:0] desc_rdata_q;
  logic          desc_we;
  logic [SW-1:0] desc_wa, desc_ra;
  logic [DW-1:0] desc_wd;

  logic          link_we_next, link_we_won;
  logic [PW-1:0] link_wa, link_ra, link_wnext, link_rnext;
  logic [SW-1:0] link_wwon, link_rwon;

  logic [swqt_pkg::NumSem-1:0]   used_q;
  logic [swqt_pkg::NumProcs-1:0] wait_q;

  swqt_pkg::req_e     req_q;
  logic [KB-1:0]      key_q;
  logic signed [15:0] nv_q;
  logic [PW-1:0]      pid_q;
  logic [SW:0]        idx_q;
  logic               found_q, free_ok_q;
  logic [SW-1:0]      fd_q, free_q;
  logic [PW-1:0]      head_q, tail_q, prev_q, nxt_q;
  logic [PW:0]        steps_q;
  logic [25:0]        out_q;

  swqt_pkg::req_e     in_req;
  logic signed [15:0] in_val, in_nv;
  logic [KB-1:0]      rd_key;
  logic [PW-1:0]      rd_head, rd_tail;
  logic [SW-1:0]      scan_prev;
  logic               scan_hit;

  swqt_link_ram u_link (
    .clk_i,
    .we_next_i(link_we_next),
    .we_won_i (link_we_won),
    .waddr_i  (link_wa),
    .wnext_i  (link_wnext),
    .wwon_i   (link_wwon),
    .raddr_i  (link_ra),
    .rnext_o  (link_rnext),
    .rwon_o   (link_rwon)
  );

  assign s_axis_tready = (state_q == swqt_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == swqt_pkg::ST_OUT);
  assign m_axis_tdata  = {6'd0, out_q};

  assign in_req    = swqt_pkg::req_e'(s_axis_tuser);
  assign in_val    = s_axis_tdata[47:32];
  assign rd_key    = desc_rdata_q[DW-1:2*PW];
  assign rd_head   = desc_rdata_q[2*PW-1:PW];
  assign rd_tail   = desc_rdata_q[PW-1:0];
  // read data of the entry addressed in the previous cycle
  assign scan_prev = SW'(idx_q - 1'b1);
  assign scan_hit  = (idx_q != '0) && used_q[scan_prev] && (rd_key == key_q);

  always_comb begin
    in_nv = in_val;
    if (in_req == swqt_pkg::REQ_P && in_val != 16'sh8000) in_nv = in_val - 16'sd1;
    if (in_req == swqt_pkg::REQ_V && in_val != 16'sh7fff) in_nv = in_val + 16'sd1;
  end

  always_comb begin
    state_d      = state_q;
    desc_we      = 1'b0;
    desc_wa      = fd_q;
    desc_wd      = {key_q, head_q, tail_q};
    desc_ra      = idx_q[SW-1:0];
    link_we_next = 1'b0;
    link_we_won  = 1'b0;
    link_wa      = prev_q;
    link_wnext   = pid_q;
    link_wwon    = fd_q;
    link_ra      = prev_q;
    unique case (state_q)
      swqt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_req == swqt_pkg::REQ_REM) state_d = swqt_pkg::ST_RD_WON;
          else if (in_req == swqt_pkg::REQ_NONE) state_d = swqt_pkg::ST_OUT;
          else state_d = swqt_pkg::ST_FIND;
        end
      end
      swqt_pkg::ST_FIND: begin
        if (idx_q == (SW+1)'(swqt_pkg::NumSem)) state_d = swqt_pkg::ST_DECIDE;
      end
      swqt_pkg::ST_DECIDE: begin
        state_d = swqt_pkg::ST_OUT;
        if (req_q == swqt_pkg::REQ_P && nv_q < 16'sd0 && !wait_q[pid_q]) begin
          if (found_q) begin
            desc_we      = 1'b1;
            desc_wa      = fd_q;
            desc_wd      = {key_q, head_q, pid_q};
            link_we_next = 1'b1;
            link_wa      = tail_q;
            link_wnext   = pid_q;
            state_d      = swqt_pkg::ST_WON;
          end else if (free_ok_q) begin
            desc_we = 1'b1;
            desc_wa = free_q;
            desc_wd = {key_q, pid_q, pid_q};
            state_d = swqt_pkg::ST_WON;
          end
        end
        if (req_q == swqt_pkg::REQ_V && nv_q <= 16'sd0 && found_q) begin
          link_ra = head_q;
          state_d = swqt_pkg::ST_POP;
        end
      end
      swqt_pkg::ST_WON: begin
        link_we_won = 1'b1;
        link_wa     = pid_q;
        link_wwon   = fd_q;
        state_d     = swqt_pkg::ST_OUT;
      end
      swqt_pkg::ST_POP: begin
        state_d = swqt_pkg::ST_OUT;
        if (tail_q != head_q) begin
          desc_we = 1'b1;
          desc_wa = fd_q;
          desc_wd = {key_q, link_rnext, tail_q};
        end
      end
      swqt_pkg::ST_RD_WON: begin
        link_ra = pid_q;
        state_d = swqt_pkg::ST_GOT_WON;
      end
      swqt_pkg::ST_GOT_WON: begin
        desc_ra = link_rwon;
        if (wait_q[pid_q] && used_q[link_rwon]) state_d = swqt_pkg::ST_REM_HEAD;
        else state_d = swqt_pkg::ST_OUT;
      end
      swqt_pkg::ST_REM_HEAD: begin
        if (rd_head == pid_q) begin
          state_d = swqt_pkg::ST_OUT;
          if (rd_tail != pid_q) begin
            desc_we = 1'b1;
            desc_wa = fd_q;
            desc_wd = {rd_key, nxt_q, rd_tail};
          end
        end else begin
          state_d = swqt_pkg::ST_WALK;
        end
      end
      swqt_pkg::ST_WALK: begin
        if (steps_q != (PW+1)'(swqt_pkg::NumProcs) && prev_q != tail_q) begin
          link_ra = prev_q;
          state_d = swqt_pkg::ST_WALK_RD;
        end else begin
          state_d = swqt_pkg::ST_OUT;
        end
      end
      swqt_pkg::ST_WALK_RD: begin
        if (link_rnext == pid_q) begin
          state_d = swqt_pkg::ST_OUT;
          if (tail_q == pid_q) begin
            desc_we = 1'b1;
            desc_wa = fd_q;
            desc_wd = {key_q, head_q, prev_q};
          end else begin
            link_we_next = 1'b1;
            link_wa      = prev_q;
            link_wnext   = nxt_q;
          end
        end else begin
          state_d = swqt_pkg::ST_WALK;
        end
      end
      swqt_pkg::ST_OUT: begin
        if (m_axis_tready) state_d = swqt_pkg::ST_IDLE;
      end
      default: state_d = swqt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[desc_wa] <= desc_wd;
    end
    desc_rdata_q <= desc_mem[desc_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swqt_pkg::ST_IDLE;
      used_q    <= '0;
      wait_q    <= '0;
      req_q     <= swqt_pkg::REQ_NONE;
      key_q     <= '0;
      nv_q      <= '0;
      pid_q     <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      fd_q      <= '0;
      free_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      prev_q    <= '0;
      nxt_q     <= '0;
      steps_q   <= '0;
      out_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        swqt_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            req_q     <= in_req;
            key_q     <= s_axis_tdata[KB-1:0];
            pid_q     <= s_axis_tdata[52:48];
            nv_q      <= in_nv;
            idx_q     <= '0;
            found_q   <= 1'b0;
            free_ok_q <= 1'b0;
            steps_q   <= '0;
            out_q     <= {10'd0, in_nv};
          end
        end
        swqt_pkg::ST_FIND: begin
          if (scan_hit && !found_q) begin
            found_q <= 1'b1;
            fd_q    <= scan_prev;
            head_q  <= rd_head;
            tail_q  <= rd_tail;
          end
          if (idx_q != (SW+1)'(swqt_pkg::NumSem)) begin
            if (!used_q[idx_q[SW-1:0]] && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= idx_q[SW-1:0];
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        swqt_pkg::ST_DECIDE: begin
          if (req_q == swqt_pkg::REQ_P && nv_q < 16'sd0) begin
            out_q[16] <= 1'b1;
            if (!wait_q[pid_q]) begin
              if (!found_q) begin
                if (free_ok_q) begin
                  used_q[free_q] <= 1'b1;
                  fd_q           <= free_q;
                end else begin
                  out_q[23] <= 1'b1;
                end
              end
            end
          end
          if (req_q == swqt_pkg::REQ_V && nv_q <= 16'sd0) begin
            if (found_q) begin
              out_q[17]    <= 1'b1;
              out_q[22:18] <= head_q;
            end else begin
              out_q[24] <= 1'b1;
            end
          end
        end
        swqt_pkg::ST_WON: begin
          wait_q[pid_q] <= 1'b1;
        end
        swqt_pkg::ST_POP: begin
          wait_q[head_q] <= 1'b0;
          if (tail_q == head_q) used_q[fd_q] <= 1'b0;
        end
        swqt_pkg::ST_GOT_WON: begin
          fd_q  <= link_rwon;
          nxt_q <= link_rnext;
        end
        swqt_pkg::ST_REM_HEAD: begin
          key_q  <= rd_key;
          head_q <= rd_head;
          tail_q <= rd_tail;
          prev_q <= rd_head;
          if (rd_head == pid_q) begin
            out_q[25]     <= 1'b1;
            wait_q[pid_q] <= 1'b0;
            if (rd_tail == pid_q) used_q[fd_q] <= 1'b0;
          end
        end
        swqt_pkg::ST_WALK_RD: begin
          if (link_rnext == pid_q) begin
            out_q[25]     <= 1'b1;
            wait_q[pid_q] <= 1'b0;
          end else begin
            prev_q  <= link_rnext;
            steps_q <= steps_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input open while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q[16] && out_q[17]))
    else $error("blocked and woken together");
endmodule
